// ===== hdl/rrd_pkg.sv =====
// shared constants, stage structs and widths for the refraction pipeline
// no dependencies; imported by every module of the block
`default_nettype none
package rrd_pkg;

	localparam int DIV_STAGES  = 8;
	localparam int DIV_STEP    = 4;
	localparam int SQRT_STAGES = 5;
	localparam int SQRT_STEP   = 3;
	localparam int LATENCY     = 19;

	localparam logic [28:0] ONE_Q28 = 29'd268435456;
	localparam logic signed [38:0] PAR_LIMIT = 39'sd1048576;

	typedef logic signed [15:0] comp_t;

	typedef struct packed {
		logic [16:0] rem;
		logic [31:0] quo;
		logic [31:0] num;
		logic [15:0] den;
	} div_st_t;

	typedef struct packed {
		logic [28:0] x;
		logic [29:0] res;
	} sqrt_st_t;

endpackage
`default_nettype wire

// ===== hdl/rrd_div.sv =====
// pipelined restoring divider, 32-bit dividend by 16-bit divisor
// depends on rrd_pkg
`default_nettype none
module rrd_div
	import rrd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic [31:0] num,
	input  wire logic [15:0] den,
	output logic      [31:0] quo
);

	div_st_t st_s  [1:DIV_STAGES];
	div_st_t nxt   [1:DIV_STAGES];

	always_comb begin
		div_st_t cur;
		for (int j = 1; j <= DIV_STAGES; j++) begin
			if (j == 1) begin
				cur.rem = '0;
				cur.quo = '0;
				cur.num = num;
				cur.den = den;
			end else begin
				cur = st_s[j-1];
			end
			for (int k = 0; k < DIV_STEP; k++) begin
				cur.rem = {cur.rem[15:0], cur.num[31]};
				cur.num = {cur.num[30:0], 1'b0};
				if (cur.rem >= {1'b0, cur.den}) begin
					cur.rem = cur.rem - {1'b0, cur.den};
					cur.quo = {cur.quo[30:0], 1'b1};
				end else begin
					cur.quo = {cur.quo[30:0], 1'b0};
				end
			end
			nxt[j] = cur;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 1; j <= DIV_STAGES; j++) begin
			st_s[j] <= nxt[j];
		end
	end

	// zero divisor gives all ones
	assign quo = st_s[DIV_STAGES].quo;

endmodule
`default_nettype wire

// ===== hdl/rrd_sqrt.sv =====
// pipelined digit-by-digit integer square root of a 29-bit value
// depends on rrd_pkg
`default_nettype none
module rrd_sqrt
	import rrd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic [28:0] x,
	output logic      [14:0] root
);

	sqrt_st_t st_s [1:SQRT_STAGES];
	sqrt_st_t nxt  [1:SQRT_STAGES];

	always_comb begin
		sqrt_st_t    cur;
		logic [29:0] bitv;
		logic [29:0] trial;
		for (int j = 1; j <= SQRT_STAGES; j++) begin
			if (j == 1) begin
				cur.x   = x;
				cur.res = '0;
			end else begin
				cur = st_s[j-1];
			end
			for (int k = 0; k < SQRT_STEP; k++) begin
				bitv  = 30'd1 << (28 - 2 * (SQRT_STEP * (j - 1) + k));
				trial = cur.res + bitv;
				if ({1'b0, cur.x} >= trial) begin
					cur.x   = 29'({1'b0, cur.x} - trial);
					cur.res = (cur.res >> 1) + bitv;
				end else begin
					cur.res = cur.res >> 1;
				end
			end
			nxt[j] = cur;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 1; j <= SQRT_STAGES; j++) begin
			st_s[j] <= nxt[j];
		end
	end

	assign root = st_s[SQRT_STAGES].res[14:0];

endmodule
`default_nettype wire

// ===== hdl/ray_refraction_direction.sv =====
// top level of the snell refraction pipeline, nineteen register stages
// depends on rrd_pkg, rrd_div and rrd_sqrt
//
//  channel   | handshake        | payload
//  ----------+------------------+----------------------------------------------
//  command   | start, busy      | dir_x/y/z, norm_x/y/z, index_in, index_out
//  result    | done (strobe)    | out_x/y/z, ratio_fault
//
// one transaction per cycle; each result is computed through the 8-stage divider and the
// 5-stage square root in series with the multiplier stages. busy is always low. reset
// clears the valid bits only. the receiver cannot stall, so the pipeline advances every cycle.
`default_nettype none
module ray_refraction_direction
	import rrd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic signed [15:0] dir_x,
	input  wire logic signed [15:0] dir_y,
	input  wire logic signed [15:0] dir_z,
	input  wire logic signed [15:0] norm_x,
	input  wire logic signed [15:0] norm_y,
	input  wire logic signed [15:0] norm_z,
	input  wire logic        [15:0] index_in,
	input  wire logic        [15:0] index_out,
	output logic             done,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic signed [15:0] out_z,
	output logic             ratio_fault
);

	logic               vld_s  [1:LATENCY];
	logic               flt_s  [1:LATENCY];
	comp_t              v_s    [1:3][3];
	comp_t              n_s    [1:17][3];
	logic signed [31:0] pr_s1  [3];
	logic signed [33:0] d_s2;
	logic signed [49:0] nd_s3  [3];
	logic signed [21:0] t_s    [4:8][3];
	logic signed [54:0] rt_s9  [3];
	logic signed [21:0] p_s    [10:18][3];
	logic signed [43:0] sq_s11 [3];
	logic        [28:0] x_s12;
	logic signed [31:0] sn_s18 [3];
	comp_t              out_s19 [3];

	logic [31:0] ratio;
	logic [14:0] root;
	comp_t       vin [3];
	comp_t       nin [3];

	assign vin = '{dir_x, dir_y, dir_z};
	assign nin = '{norm_x, norm_y, norm_z};

	rrd_div u_div (
		.clk (clk),
		.num ({index_in, 16'd0}),
		.den (index_out),
		.quo (ratio)
	);

	rrd_sqrt u_sqrt (
		.clk  (clk),
		.x    (x_s12),
		.root (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LATENCY; k++) vld_s[k] <= 1'b0;
		end else begin
			vld_s[1] <= start && !busy;
			for (int k = 2; k <= LATENCY; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		logic signed [49:0] tsum;
		logic signed [54:0] rsum;
		logic signed [38:0] psh;
		logic signed [45:0] len;
		logic signed [33:0] qsum;
		logic signed [19:0] q;
		logic signed [22:0] o;
		flt_s[1] <= (index_out == 16'd0);
		for (int k = 2; k <= LATENCY; k++) flt_s[k] <= flt_s[k-1];
		for (int i = 0; i < 3; i++) begin
			// dot product and tangential part
			v_s[1][i] <= vin[i];
			n_s[1][i] <= nin[i];
			pr_s1[i]  <= vin[i] * nin[i];
			for (int k = 2; k <= 3; k++) v_s[k][i] <= v_s[k-1][i];
			for (int k = 2; k <= 17; k++) n_s[k][i] <= n_s[k-1][i];
			nd_s3[i] <= n_s[2][i] * d_s2;
			tsum = {{6{v_s[3][i][15]}}, v_s[3][i], 28'd0} - nd_s3[i] + 50'sd134217728;
			t_s[4][i] <= tsum[49:28];
			for (int k = 5; k <= 8; k++) t_s[k][i] <= t_s[k-1][i];
			// scale by index ratio and clamp
			rt_s9[i] <= $signed({1'b0, ratio}) * t_s[8][i];
			rsum = rt_s9[i] + 55'sd32768;
			psh  = rsum[54:16];
			if (psh > PAR_LIMIT) begin
				p_s[10][i] <= 22'(PAR_LIMIT);
			end else if (psh < -PAR_LIMIT) begin
				p_s[10][i] <= 22'(-PAR_LIMIT);
			end else begin
				p_s[10][i] <= psh[21:0];
			end
			for (int k = 11; k <= 18; k++) p_s[k][i] <= p_s[k-1][i];
			sq_s11[i] <= p_s[10][i] * p_s[10][i];
			// normal part and saturation
			sn_s18[i] <= $signed({1'b0, root}) * n_s[17][i];
			qsum = 34'sd8192 - 34'(sn_s18[i]);
			q    = qsum[33:14];
			o    = 23'(p_s[18][i]) + 23'(q);
			if (o > 23'sd32767) begin
				out_s19[i] <= 16'sh7fff;
			end else if (o < -23'sd32768) begin
				out_s19[i] <= 16'sh8000;
			end else begin
				out_s19[i] <= o[15:0];
			end
		end
		d_s2 <= 34'(pr_s1[0]) + 34'(pr_s1[1]) + 34'(pr_s1[2]);
		len  = 46'(sq_s11[0]) + 46'(sq_s11[1]) + 46'(sq_s11[2]);
		if (len > 46'(ONE_Q28)) begin
			x_s12 <= '0;
		end else begin
			x_s12 <= ONE_Q28 - len[28:0];
		end
	end

	assign busy        = 1'b0;
	assign done        = vld_s[LATENCY];
	assign ratio_fault = flt_s[LATENCY];
	assign out_x       = out_s19[0];
	assign out_y       = out_s19[1];
	assign out_z       = out_s19[2];

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##19 done) else $error("result missing");
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 19)) else $error("result without command");
	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		done && ratio_fault |-> $past(index_out == 16'd0, 19)) else $error("false fault");
	a_nofault: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ratio_fault |-> $past(index_out != 16'd0, 19)) else $error("fault lost");

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// self-checking testbench for ray_refraction_direction: snell refraction of q2.14 vectors
// holds its own bit-exact predictor; drives directed and random transactions with idle gaps
// depends on rrd_pkg and the ray_refraction_direction rtl
`timescale 1ns / 1ps
module tb
	import rrd_pkg::*;
();

	typedef struct {
		comp_t ox;
		comp_t oy;
		comp_t oz;
		logic  fault;
	} refr_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	comp_t dir_x = '0, dir_y = '0, dir_z = '0;
	comp_t norm_x = '0, norm_y = '0, norm_z = '0;
	logic [15:0] index_in = '0, index_out = '0;
	logic done;
	comp_t out_x, out_y, out_z;
	logic ratio_fault;

	refr_t pending_dirs[$];
	int errors = 0;
	int cycles = 0;
	int idle_pct = 0;

	ray_refraction_direction uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
		.index_in(index_in), .index_out(index_out),
		.done(done), .out_x(out_x), .out_y(out_y), .out_z(out_z),
		.ratio_fault(ratio_fault)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 200000) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic longint rnd_shift(longint x, int k);
		return (x + (longint'(1) << (k - 1))) >>> k;
	endfunction

	function automatic longint clamp(longint x, longint lo, longint hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	function automatic longint floor_sqrt(longint unsigned x);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 30;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic refr_t refract(comp_t vx, comp_t vy, comp_t vz,
			comp_t nx, comp_t ny, comp_t nz, logic [15:0] ein, logic [15:0] eout);
		longint v[3], n[3], p[3], o[3];
		longint d, r, len2, s, t;
		longint unsigned num;
		refr_t res;
		v[0] = vx; v[1] = vy; v[2] = vz;
		n[0] = nx; n[1] = ny; n[2] = nz;
		d = 0;
		len2 = 0;
		for (int i = 0; i < 3; i++) d += v[i] * n[i];
		res.fault = (eout == 0);
		if (eout == 0) begin
			r = 64'hFFFF_FFFF;
		end else begin
			num = longint'(ein) << 16;
			r = longint'(num / eout);
		end
		for (int i = 0; i < 3; i++) begin
			t = rnd_shift(v[i] * (longint'(1) << 28) - n[i] * d, 28);
			p[i] = clamp(rnd_shift(r * t, 16), -(longint'(1) << 20), longint'(1) << 20);
			len2 += p[i] * p[i];
		end
		if (len2 > (longint'(1) << 28)) len2 = longint'(1) << 28;
		s = floor_sqrt((longint'(1) << 28) - len2);
		for (int i = 0; i < 3; i++)
			o[i] = clamp(p[i] + rnd_shift(-(s * n[i]), 14), -32768, 32767);
		res.ox = comp_t'(o[0]);
		res.oy = comp_t'(o[1]);
		res.oz = comp_t'(o[2]);
		return res;
	endfunction

	always @(posedge clk) begin
		refr_t want;
		if (arst_n && done) begin
			if (pending_dirs.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d z=%0d fault=%0b",
					$time, out_x, out_y, out_z, ratio_fault);
				errors++;
			end else begin
				want = pending_dirs.pop_front();
				if (out_x !== want.ox) begin
					$display("%0t: out_x expected %0d actual %0d", $time, want.ox, out_x);
					errors++;
				end
				if (out_y !== want.oy) begin
					$display("%0t: out_y expected %0d actual %0d", $time, want.oy, out_y);
					errors++;
				end
				if (out_z !== want.oz) begin
					$display("%0t: out_z expected %0d actual %0d", $time, want.oz, out_z);
					errors++;
				end
				if (ratio_fault !== want.fault) begin
					$display("%0t: ratio_fault expected %0b actual %0b",
						$time, want.fault, ratio_fault);
					errors++;
				end
			end
		end
	end

	task automatic send_ray(comp_t vx, comp_t vy, comp_t vz, comp_t nx, comp_t ny, comp_t nz,
			logic [15:0] ein, logic [15:0] eout);
		@(negedge clk);
		dir_x = vx; dir_y = vy; dir_z = vz;
		norm_x = nx; norm_y = ny; norm_z = nz;
		index_in = ein; index_out = eout;
		start = 1'b1;
		do @(posedge clk); while (busy);
		pending_dirs.push_back(refract(vx, vy, vz, nx, ny, nz, ein, eout));
		if ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(3)) @(negedge clk);
		end
	endtask

	task automatic drain;
		@(negedge clk);
		start = 1'b0;
		while (pending_dirs.size() != 0) @(negedge clk);
	endtask

	function automatic comp_t rnd_comp(int mag);
		return comp_t'($urandom_range(2 * mag) - mag);
	endfunction

	task automatic test_directed;
		send_ray(0, 0, 16384, 0, 0, -16384, 4096, 4096);
		send_ray(11585, 0, -11585, 0, 0, 16384, 4096, 6144);
		send_ray(11585, 0, -11585, 0, 0, 16384, 6144, 4096);
		send_ray(15000, 0, -6000, 0, 0, 16384, 10240, 4096);
		send_ray(9000, 9000, -9000, 0, 16384, 0, 4096, 0);
		send_ray(9000, 9000, -9000, 0, 16384, 0, 0, 4096);
		send_ray(9000, 9000, -9000, 0, 16384, 0, 0, 0);
		send_ray(32767, 32767, 32767, 32767, 32767, 32767, 16'hFFFF, 1);
		send_ray(-32768, -32768, -32768, -32768, -32768, -32768, 16'hFFFF, 16'hFFFF);
		send_ray(32767, -32768, 0, -32768, 32767, 0, 1, 16'hFFFF);
		send_ray(0, 0, 0, 0, 0, 0, 4096, 4096);
		send_ray(8000, -3000, 12000, 0, 0, 0, 4096, 5000);
		send_ray(8000, -3000, 12000, 4000, 2000, -1000, 4096, 5000);
		send_ray(-16384, 0, 0, 16384, 0, 0, 6000, 4000);
		send_ray(5000, 12000, -8000, 9459, 9459, 9459, 5461, 4096);
		send_ray(-32768, 32767, 1, 1, -1, 32767, 16'hFFFF, 0);
		drain();
	endtask

	task automatic test_random(int count, int pct);
		int kind;
		idle_pct = pct;
		for (int k = 0; k < count; k++) begin
			kind = $urandom_range(9);
			if (kind < 2)
				send_ray(comp_t'($urandom), comp_t'($urandom), comp_t'($urandom),
					comp_t'($urandom), comp_t'($urandom), comp_t'($urandom),
					16'($urandom), 16'($urandom));
			else if (kind < 5)
				send_ray(rnd_comp(16384), rnd_comp(16384), rnd_comp(16384),
					comp_t'(0), comp_t'(0),
					($urandom_range(1) ? comp_t'(16384) : comp_t'(-16384)),
					16'($urandom_range(4096, 10240)), 16'($urandom_range(4096, 10240)));
			else
				send_ray(rnd_comp(16384), rnd_comp(16384), rnd_comp(16384),
					rnd_comp(9459), rnd_comp(9459), rnd_comp(9459),
					16'($urandom_range(2048, 12288)), ($urandom_range(30) == 0) ? 16'd0 :
					16'($urandom_range(2048, 12288)));
			if (k == count / 2) drain();
		end
		drain();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(250, 0);
		test_random(250, 55);
		test_random(250, 55);
		test_random(250, 13);
		repeat (40) @(posedge clk);
		if (errors == 0 && pending_dirs.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/rrd_pkg.sv
hdl/rrd_div.sv
hdl/rrd_sqrt.sv
hdl/ray_refraction_direction.sv
sim/tb.sv
